>>> src/dwsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwsp_pkg: shared types and constants for the dual wheel speed controller
// Field widths, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package dwsp_pkg;

  localparam int unsigned CountW     = 16;
  localparam int unsigned SetpointW  = 10;
  localparam int unsigned GainW      = 8;
  localparam int unsigned DriveW     = 16;
  localparam int unsigned IntLimitW  = 15;
  localparam int unsigned IntegW     = 16;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 16;

  // Register indexes on the configuration channel.
  localparam logic [CfgIndexW-1:0] RegPropGain      = 2'd0;
  localparam logic [CfgIndexW-1:0] RegDriveLimit    = 2'd1;
  localparam logic [CfgIndexW-1:0] RegIntegralLimit = 2'd2;
  localparam logic [CfgIndexW-1:0] RegMoveThreshold = 2'd3;

  // Values after reset.
  localparam logic [GainW-1:0]     ResetPropGain      = 8'd6;
  localparam logic [DriveW-1:0]    ResetDriveLimit    = 16'd800;
  localparam logic [IntLimitW-1:0] ResetIntegralLimit = 15'd4000;
  localparam logic [SetpointW-1:0] ResetMoveThreshold = 10'd5;

  // Reciprocal of three in 16 fractional bits; exact for magnitudes below 2^15.
  localparam logic [14:0] RecipThree = 15'd21846;

  typedef struct packed {
    logic [GainW-1:0]     prop_gain;
    logic [DriveW-1:0]    drive_limit;
    logic [IntLimitW-1:0] integral_limit;
    logic [SetpointW-1:0] move_threshold;
  } cfg_t;

endpackage

>>> src/dwsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwsp_if: valid/ready channels of the dual wheel speed controller
// Request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface dwsp_in_if import dwsp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CountW-1:0]    left_count;
  logic [CountW-1:0]    right_count;
  logic [SetpointW-1:0] speed_setpoint;

  modport source (output valid, left_count, right_count, speed_setpoint, input ready);
  modport sink   (input valid, left_count, right_count, speed_setpoint, output ready);
endinterface

interface dwsp_out_if import dwsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DriveW-1:0] left_drive;
  logic [DriveW-1:0] right_drive;
  logic [CountW-1:0] left_speed;
  logic [CountW-1:0] right_speed;
  logic              stopped;

  modport source (output valid, left_drive, right_drive, left_speed, right_speed, stopped,
                  input ready);
  modport sink   (input valid, left_drive, right_drive, left_speed, right_speed, stopped,
                  output ready);
endinterface

interface dwsp_cfg_if import dwsp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/dwsp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwsp_cfg_regs: configuration register file
// Takes writes from the configuration channel and holds the four settings.
// ----------------------------------------------------------------------------
module dwsp_cfg_regs import dwsp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  dwsp_cfg_if.sink cfg_i,
  output cfg_t     cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegPropGain:      cfg_d.prop_gain      = cfg_i.data[GainW-1:0];
        RegDriveLimit:    cfg_d.drive_limit    = cfg_i.data[DriveW-1:0];
        RegIntegralLimit: cfg_d.integral_limit = cfg_i.data[IntLimitW-1:0];
        RegMoveThreshold: cfg_d.move_threshold = cfg_i.data[SetpointW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain      <= ResetPropGain;
      cfg_q.drive_limit    <= ResetDriveLimit;
      cfg_q.integral_limit <= ResetIntegralLimit;
      cfg_q.move_threshold <= ResetMoveThreshold;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/dwsp_wheel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwsp_wheel: PI loop of one wheel
// Speed from the count delta, clamped integrator (cleared at or below the move
// threshold) and saturated drive command.
module dwsp_wheel import dwsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [CountW-1:0]    count_i,
  input  logic [SetpointW-1:0] setpoint_i,
  input  cfg_t                 cfg_i,
  output logic [DriveW-1:0]    drive_o,
  output logic [CountW-1:0]    speed_o
);

  logic [CountW-1:0]        prev_q;
  logic signed [IntegW-1:0] integ_q, integ_d;

  logic [CountW-1:0]        speed;
  logic signed [16:0]       err;
  logic signed [17:0]       acc;
  logic signed [17:0]       lim;
  logic signed [17:0]       clamped;
  logic                     neg;
  logic [IntegW-1:0]        mag;
  logic [29:0]              prod;
  logic signed [14:0]       quot;
  logic signed [25:0]       pterm;
  logic signed [26:0]       cmd;

  assign speed = count_i - prev_q;
  assign err   = $signed({7'b0, setpoint_i}) - $signed({1'b0, speed});
  assign acc   = 18'(integ_q) + 18'(err);
  assign lim   = $signed({3'b0, cfg_i.integral_limit});

  always_comb begin
    if (acc >= lim) begin
      clamped = lim;
    end else if (acc <= -lim) begin
      clamped = -lim;
    end else begin
      clamped = acc;
    end
    integ_d = (setpoint_i > cfg_i.move_threshold) ? clamped[IntegW-1:0] : '0;
  end

  // Integrator divided by three, truncating toward zero, by sign and magnitude.
  assign neg  = integ_d[IntegW-1];
  assign mag  = neg ? (-integ_d) : integ_d;
  assign prod = 30'(mag[14:0]) * 30'(RecipThree);
  assign quot = neg ? -$signed({1'b0, prod[29:16]}) : $signed({1'b0, prod[29:16]});

  assign pterm = 26'(err) * 26'($signed({1'b0, cfg_i.prop_gain}));
  assign cmd   = 27'(pterm) + 27'(quot);

  always_comb begin
    if (cmd < 0) begin
      drive_o = '0;
    end else if (cmd > $signed({11'b0, cfg_i.drive_limit})) begin
      drive_o = cfg_i.drive_limit;
    end else begin
      drive_o = cmd[DriveW-1:0];
    end
  end

  assign speed_o = speed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      integ_q <= '0;
    end else if (step_i) begin
      prev_q  <= count_i;
      integ_q <= integ_d;
    end
  end

endmodule

>>> src/dual_wheel_speed_pi.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_wheel_speed_pi: PI speed controller for two wheels
// One request per control tick in, one set of drive commands and speeds out.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request per control tick: both wheels' encoder counts
//   and the common speed setpoint. out_o returns exactly one result per
//   request: both saturated drive commands, both measured speeds and the
//   stopped flag. cfg_i writes one of four registers (gain, drive limit,
//   integral limit, move threshold) by index; write only while no request
//   is in flight.
//   After a request is accepted, it is captured in an input register, the
//   per-wheel PI math runs in one pass of combinational logic, and the
//   result lands in the output register, held there until it is taken.
//   Throughput is one request per cycle while the receiver does not stall;
//   the limit is the loop through each wheel's integrator and
//   previous-count register.
//   Reset clears both integrators and previous counts to zero and loads the
//   register defaults. When the receiver stalls, the held result waits in
//   the output register while the input register still takes one more
//   request; in_i.ready drops only when both are full.
// ----------------------------------------------------------------------------
module dual_wheel_speed_pi import dwsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dwsp_in_if.sink     in_i,
  dwsp_cfg_if.sink    cfg_i,
  dwsp_out_if.source  out_o
);

  cfg_t cfg;

  // Input register stage.
  logic                 s1_valid_q;
  logic [CountW-1:0]    s1_left_q;
  logic [CountW-1:0]    s1_right_q;
  logic [SetpointW-1:0] s1_setpoint_q;

  // Result register stage.
  logic              out_valid_q;
  logic [DriveW-1:0] left_drive_q, right_drive_q;
  logic [CountW-1:0] left_speed_q, right_speed_q;
  logic              stopped_q;

  logic [DriveW-1:0] left_drive, right_drive;
  logic [CountW-1:0] left_speed, right_speed;

  logic advance;
  logic accept;

  // The stage moves forward when the result register is free or being drained.
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign accept     = in_i.valid && in_i.ready;

  dwsp_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Wheel state is committed only when its request moves to the result register,
  // so the next request sees the updated counts and integrators.
  dwsp_wheel u_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .count_i    (s1_left_q),
    .setpoint_i (s1_setpoint_q),
    .cfg_i      (cfg),
    .drive_o    (left_drive),
    .speed_o    (left_speed)
  );

  dwsp_wheel u_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .count_i    (s1_right_q),
    .setpoint_i (s1_setpoint_q),
    .cfg_i      (cfg),
    .drive_o    (right_drive),
    .speed_o    (right_speed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_left_q     <= in_i.left_count;
      s1_right_q    <= in_i.right_count;
      s1_setpoint_q <= in_i.speed_setpoint;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      left_drive_q  <= left_drive;
      right_drive_q <= right_drive;
      left_speed_q  <= left_speed;
      right_speed_q <= right_speed;
      stopped_q     <= (left_drive == '0) && (right_drive == '0);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.left_drive  = left_drive_q;
  assign out_o.right_drive = right_drive_q;
  assign out_o.left_speed  = left_speed_q;
  assign out_o.right_speed = right_speed_q;
  assign out_o.stopped     = stopped_q;

  // An accepted request always occupies the input register next cycle.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted request did not reach the input register");

  // A request moved forward always shows up as a valid result.
  a_advance_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced request produced no result");

  // With both registers full and the receiver stalled, no request may enter.
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("request accepted while pipeline full and stalled");

  // The stopped flag matches the registered drives.
  a_stopped_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (stopped_q == ((left_drive_q == '0) && (right_drive_q == '0))))
    else $error("stopped flag disagrees with drive commands");

endmodule
